/* rtl/differential_drive_to_point_macros.svh */
// Assertion macros for the go-to-point drive pipeline.
// No dependencies; included by the modules that assert.
`ifndef DIFFERENTIAL_DRIVE_TO_POINT_MACROS_SVH
`define DIFFERENTIAL_DRIVE_TO_POINT_MACROS_SVH
`ifndef SYNTHESIS
`define DDP_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DDP_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DDP_ASSERT(label, clk, rst_n, prop, msg)
`define DDP_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

/* rtl/ddp_pkg.sv */
// Shared types and constants of the go-to-point drive pipeline.
// No dependencies.
`default_nettype none
package ddp_pkg;
  localparam int HALF_TURN = 11520;
  localparam int FULL_TURN = 23040;
  localparam int INV_GAIN_Q16 = 39797;
  localparam int ZW = 24;

  typedef enum logic [2:0] {
    REG_TARGET_X = 3'd0, REG_TARGET_Y = 3'd1, REG_TARGET_HEADING = 3'd2,
    REG_MAX_SPEED = 3'd3, REG_DRIVE_MODE = 3'd4, REG_DRIVE_GAIN = 3'd5,
    REG_TURN_GAIN = 3'd6, REG_ARRIVE_RADIUS = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_FWD = 2'd0, MODE_REV = 2'd1, MODE_HEAD = 2'd2, MODE_SPARE = 2'd3
  } mode_t;

  typedef struct packed {
    logic signed [23:0] target_x;
    logic signed [23:0] target_y;
    logic signed [14:0] target_heading;
    logic [14:0]        max_speed;
    mode_t              drive_mode;
    logic [11:0]        drive_gain;
    logic [11:0]        turn_gain;
    logic [15:0]        arrive_radius;
  } cfg_t;

  function automatic logic [ZW-1:0] atan_entry(input int i);
    logic [ZW-1:0] r;
    case (i)
      0: r = 24'd737280;  1: r = 24'd435242;  2: r = 24'd229970;
      3: r = 24'd116736;  4: r = 24'd58595;   5: r = 24'd29326;
      6: r = 24'd14667;   7: r = 24'd7334;    8: r = 24'd3667;
      9: r = 24'd1833;    10: r = 24'd917;    11: r = 24'd458;
      12: r = 24'd229;    13: r = 24'd115;    14: r = 24'd57;
      15: r = 24'd29;     16: r = 24'd14;     17: r = 24'd7;
      18: r = 24'd4;      19: r = 24'd2;      20: r = 24'd1;
      default: r = '0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

/* rtl/ddp_cordic.sv */
// Pipelined vectoring CORDIC: magnitude and angle of (dx, dy), one stage per register.
// Depends on ddp_pkg.
`default_nettype none
`include "differential_drive_to_point_macros.svh"
module ddp_cordic
  import ddp_pkg::*;
#(
  parameter int STAGES = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_vld,
  input  wire logic signed [24:0] in_dx,
  input  wire logic signed [24:0] in_dy,
  input  wire logic [15:0]        in_tag,
  output logic                    out_vld,
  output logic [35:0]             out_x,
  output logic signed [ZW-1:0]    out_z,
  output logic                    out_zero,
  output logic [15:0]             out_tag
);
  // x grows by up to gain*sqrt2 over 33 bits; 36 bits leave margin
  localparam int XW = 36;
  logic                 vld_r  [STAGES+1];
  logic signed [XW-1:0] x_r    [STAGES+1];
  logic signed [XW-1:0] y_r    [STAGES+1];
  logic signed [ZW-1:0] z_r    [STAGES+1];
  logic                 zero_r [STAGES+1];
  logic [15:0]          tag_r  [STAGES+1];

  // pre-rotation into the right half plane
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r[0] <= 1'b0;
    else        vld_r[0] <= in_vld;
    zero_r[0] <= (in_dx == '0) && (in_dy == '0);
    tag_r[0]  <= in_tag;
    if (in_dx < 0) begin
      x_r[0] <= -(XW'(in_dx) <<< 8);
      y_r[0] <= -(XW'(in_dy) <<< 8);
      z_r[0] <= (in_dy >= 0) ? ZW'(HALF_TURN * 256) : -ZW'(HALF_TURN * 256);
    end else begin
      x_r[0] <= XW'(in_dx) <<< 8;
      y_r[0] <= XW'(in_dy) <<< 8;
      z_r[0] <= '0;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[i+1] <= 1'b0;
      else        vld_r[i+1] <= vld_r[i];
      zero_r[i+1] <= zero_r[i];
      tag_r[i+1]  <= tag_r[i];
      if (y_r[i] >= 0) begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] + atan_entry(i);
      end else begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] - atan_entry(i);
      end
    end
  end

  assign out_vld  = vld_r[STAGES];
  assign out_x    = x_r[STAGES][XW-1] ? '0 : x_r[STAGES];
  assign out_z    = z_r[STAGES];
  assign out_zero = zero_r[STAGES];
  assign out_tag  = tag_r[STAGES];

  `DDP_ASSERT(a_vld_flow, clk, rst_n, vld_r[0] |-> ##STAGES out_vld, "cordic lost an item")
  `DDP_ASSERT(a_xpos, clk, rst_n, out_vld |-> !out_x[XW-1], "negative magnitude")
  `DDP_ASSERT_RST(a_rst, clk, !rst_n |=> !vld_r[0], "valid after reset")
endmodule
`default_nettype wire

/* rtl/ddp_control.sv */
// Gain, wrap, clamp and mixing stages after the CORDIC.
// Depends on ddp_pkg.
`default_nettype none
module ddp_control
  import ddp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cfg_t               cfg,
  input  wire logic               in_vld,
  input  wire logic [35:0]        in_x,
  input  wire logic signed [23:0] in_z,
  input  wire logic               in_zero,
  input  wire logic signed [15:0] in_head,
  output logic                    out_strobe,
  output logic signed [16:0]      out_left_power,
  output logic signed [16:0]      out_right_power,
  output logic                    out_arrived
);
  function automatic logic signed [31:0] clampm(input logic signed [31:0] v,
                                                input logic [14:0] m);
    logic signed [31:0] mm;
    mm = 32'(m);
    if (v > mm) return mm;
    if (v < -mm) return -mm;
    return v;
  endfunction

  // stage A: scale magnitude (lower/upper partial products), bearing
  logic               a_vld_r;
  logic [53:0]        a_plo_r;
  logic [35:0]        a_phi_r;
  logic signed [15:0] a_bear_r;
  logic signed [15:0] a_head_r;
  logic signed [24:0] zr;
  always_comb zr = (25'(in_z) + 25'sd128) >>> 8;
  always_ff @(posedge clk) begin
    if (!rst_n) a_vld_r <= 1'b0;
    else        a_vld_r <= in_vld;
    a_plo_r  <= 54'(in_x[17:0]) * 54'(INV_GAIN_Q16);
    a_phi_r  <= 36'(in_x[35:18]) * 36'(INV_GAIN_Q16);
    a_bear_r <= in_zero ? '0 : 16'(zr);
    a_head_r <= in_head;
  end

  // stage B: distance, arrival, heading error
  logic               b_vld_r;
  logic [24:0]        b_dist_r;
  logic               b_arr_r;
  logic signed [17:0] b_err_r;
  logic [55:0]        dsum;
  logic [24:0]        b_dist_nxt;
  logic signed [17:0] ref_h, err;
  always_comb begin
    dsum = 56'(a_plo_r) + (56'(a_phi_r) << 18) + 56'd8388608;
    b_dist_nxt = 25'(dsum >> 24);
    unique case (cfg.drive_mode)
      MODE_HEAD: ref_h = 18'(cfg.target_heading);
      MODE_REV: begin
        ref_h = 18'(a_bear_r) + 18'sd11520;
        if (ref_h > 18'sd11520) ref_h = ref_h - 18'(FULL_TURN);
      end
      default: ref_h = 18'(a_bear_r);
    endcase
    err = ref_h - 18'(a_head_r);
    // err stays within two and a half turns either way, so two corrections each way suffice
    for (int k = 0; k < 2; k++) begin
      if (err > 18'sd11520) err = err - 18'(FULL_TURN);
      else if (err < -18'sd11520) err = err + 18'(FULL_TURN);
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) b_vld_r <= 1'b0;
    else        b_vld_r <= a_vld_r;
    b_dist_r <= b_dist_nxt;
    b_arr_r  <= (dsum >> 24) < 56'(cfg.arrive_radius);
    b_err_r  <= err;
  end

  // stage C: gains and first clamp
  logic               c_vld_r, c_arr_r;
  logic signed [16:0] c_drive_r, c_turn_r;
  logic [40:0]        dprod;
  logic signed [31:0] tprod, dv, tv;
  always_comb begin
    dprod = 41'(b_dist_r) * 41'(cfg.drive_gain) + 41'd128;
    tprod = 32'(b_err_r) * $signed({20'd0, cfg.turn_gain}) + 32'sd32;
    dv = (dprod[40:8] > 33'(cfg.max_speed)) ? 32'(cfg.max_speed) : 32'(dprod[40:8]);
    tv = clampm(tprod >>> 6, cfg.max_speed);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) c_vld_r <= 1'b0;
    else        c_vld_r <= b_vld_r;
    c_arr_r   <= b_arr_r;
    c_drive_r <= 17'(dv);
    c_turn_r  <= 17'(tv);
  end

  // stage D: mixing and output register
  logic signed [31:0] l, r;
  always_comb begin
    if (cfg.drive_mode == MODE_REV) begin
      l = -32'(c_drive_r) + 32'(c_turn_r);
      r = -32'(c_drive_r) - 32'(c_turn_r);
    end else begin
      l = 32'(c_drive_r) + 32'(c_turn_r);
      r = 32'(c_drive_r) - 32'(c_turn_r);
      if (cfg.drive_mode == MODE_HEAD) begin
        l = clampm(l, cfg.max_speed);
        r = clampm(r, cfg.max_speed);
      end
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) out_strobe <= 1'b0;
    else        out_strobe <= c_vld_r;
    out_left_power  <= c_arr_r ? '0 : 17'(l);
    out_right_power <= c_arr_r ? '0 : 17'(r);
    out_arrived     <= c_arr_r;
  end
endmodule
`default_nettype wire

/* rtl/differential_drive_to_point.sv */
// Go-to-point drive controller for a differential-drive base, one pose item a cycle.
// A start with busy low enters a pipeline of CORDIC_STAGES+1 CORDIC stages and four
// control stages; out_strobe is registered in the last control stage, high for one cycle,
// and the receiver cannot stall. busy is always low. Configuration is read live, so write
// it only while the pipeline is empty. Depends on ddp_pkg and ddp_cordic, ddp_control.
`default_nettype none
module differential_drive_to_point
  import ddp_pkg::*;
#(
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [23:0] in_pose_x,
  input  wire logic signed [23:0] in_pose_y,
  input  wire logic signed [15:0] in_pose_heading,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [23:0]        cfg_data,
  output logic                    out_strobe,
  output logic signed [16:0]      out_left_power,
  output logic signed [16:0]      out_right_power,
  output logic                    out_arrived
);
  cfg_t cfg_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{target_x: '0, target_y: '0, target_heading: '0, max_speed: 15'd17920,
                 drive_mode: MODE_FWD, drive_gain: 12'd563, turn_gain: 12'd768,
                 arrive_radius: 16'd192};
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_TARGET_X:       cfg_r.target_x <= cfg_data;
        REG_TARGET_Y:       cfg_r.target_y <= cfg_data;
        REG_TARGET_HEADING: cfg_r.target_heading <= cfg_data[14:0];
        REG_MAX_SPEED:      cfg_r.max_speed <= cfg_data[14:0];
        REG_DRIVE_MODE:     cfg_r.drive_mode <= mode_t'(cfg_data[1:0]);
        REG_DRIVE_GAIN:     cfg_r.drive_gain <= cfg_data[11:0];
        REG_TURN_GAIN:      cfg_r.turn_gain <= cfg_data[11:0];
        REG_ARRIVE_RADIUS:  cfg_r.arrive_radius <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic               c_vld, c_zero;
  logic [35:0]        c_x;
  logic signed [23:0] c_z;
  logic [15:0]        c_tag;

  ddp_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
    .clk, .rst_n,
    .in_vld (start),
    .in_dx  (25'(cfg_r.target_x) - 25'(in_pose_x)),
    .in_dy  (25'(cfg_r.target_y) - 25'(in_pose_y)),
    .in_tag (in_pose_heading),
    .out_vld(c_vld), .out_x(c_x), .out_z(c_z), .out_zero(c_zero), .out_tag(c_tag)
  );

  ddp_control u_ctrl (
    .clk, .rst_n, .cfg(cfg_r),
    .in_vld(c_vld), .in_x(c_x), .in_z(c_z), .in_zero(c_zero), .in_head(c_tag),
    .out_strobe, .out_left_power, .out_right_power, .out_arrived
  );
endmodule
`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for differential_drive_to_point: pose items in, drive powers out.
// Depends on ddp_pkg and the RTL; predicts each result with its own CORDIC model.
`timescale 1ns / 1ps
module tb;
  import ddp_pkg::*;

  localparam int STAGES = 16;
  localparam int LATENCY = STAGES + 5;
  localparam int N_RANDOM = 1950;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [23:0] in_pose_x = '0;
  logic signed [23:0] in_pose_y = '0;
  logic signed [15:0] in_pose_heading = '0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;
  logic out_strobe;
  logic signed [16:0] out_left_power, out_right_power;
  logic out_arrived;

  typedef struct packed {
    logic signed [16:0] left;
    logic signed [16:0] right;
    logic arrived;
  } drive_cmd_t;

  typedef struct {
    longint px, py, ph;
    bit has_known;
    longint kl, kr;
    bit ka;
  } pose_row_t;

  cfg_t cfg_shadow;
  drive_cmd_t pending_cmds[$];
  int fail_count = 0;

  always #4 clk = ~clk;

  differential_drive_to_point #(.CORDIC_STAGES(STAGES)) u_dut (
    .clk, .rst_n, .start, .busy, .in_pose_x, .in_pose_y, .in_pose_heading,
    .cfg_we, .cfg_index, .cfg_data, .out_strobe, .out_left_power,
    .out_right_power, .out_arrived
  );

  function automatic longint sat_mag(longint v, longint m);
    if (v > m) return m;
    if (v < -m) return -m;
    return v;
  endfunction

  function automatic longint angle_step(int i);
    longint t[24] = '{737280, 435242, 229970, 116736, 58595, 29326, 14667, 7334,
                      3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0, 0, 0};
    return t[i];
  endfunction

  function automatic drive_cmd_t predict_drive(longint px, longint py, longint ph);
    longint dx, dy, x, y, z, xs, ys, dist_v, bear, hdg_ref, err, drv, trn, l, r;
    longint tx, ty, th, ms;
    drive_cmd_t c;
    tx = cfg_shadow.target_x;
    ty = cfg_shadow.target_y;
    th = cfg_shadow.target_heading;
    ms = cfg_shadow.max_speed;
    dx = tx - px;
    dy = ty - py;
    x = dx * 256;
    y = dy * 256;
    z = 0;
    if (x < 0) begin
      z = (y >= 0) ? HALF_TURN * 256 : -HALF_TURN * 256;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < STAGES && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z += angle_step(i);
      end else begin
        x = x - ys; y = y + xs; z -= angle_step(i);
      end
    end
    if (x < 0) x = 0;
    dist_v = (x * INV_GAIN_Q16 + (longint'(1) << 23)) >>> 24;
    bear = (dx == 0 && dy == 0) ? 0 : ((z + 128) >>> 8);
    c = '0;
    if (dist_v < longint'(cfg_shadow.arrive_radius)) begin
      c.arrived = 1'b1;
      return c;
    end
    if (cfg_shadow.drive_mode == MODE_HEAD) hdg_ref = th;
    else if (cfg_shadow.drive_mode == MODE_REV) begin
      hdg_ref = bear + HALF_TURN;
      if (hdg_ref > HALF_TURN) hdg_ref -= FULL_TURN;
    end else hdg_ref = bear;
    err = hdg_ref - ph;
    while (err > HALF_TURN) err -= FULL_TURN;
    while (err < -HALF_TURN) err += FULL_TURN;
    drv = sat_mag((dist_v * longint'(cfg_shadow.drive_gain) + 128) >>> 8, ms);
    trn = sat_mag((err * longint'(cfg_shadow.turn_gain) + 32) >>> 6, ms);
    if (cfg_shadow.drive_mode == MODE_REV) begin
      l = -drv + trn;
      r = -drv - trn;
    end else begin
      l = drv + trn;
      r = drv - trn;
      if (cfg_shadow.drive_mode == MODE_HEAD) begin
        l = sat_mag(l, ms);
        r = sat_mag(r, ms);
      end
    end
    c.left = l[16:0];
    c.right = r[16:0];
    return c;
  endfunction

  // write enable stays up until the next pose item clears it
  task automatic write_reg(reg_idx_t idx, longint val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[23:0];
    @(posedge clk);
    case (idx)
      REG_TARGET_X: cfg_shadow.target_x = val[23:0];
      REG_TARGET_Y: cfg_shadow.target_y = val[23:0];
      REG_TARGET_HEADING: cfg_shadow.target_heading = val[14:0];
      REG_MAX_SPEED: cfg_shadow.max_speed = val[14:0];
      REG_DRIVE_MODE: cfg_shadow.drive_mode = mode_t'(val[1:0]);
      REG_DRIVE_GAIN: cfg_shadow.drive_gain = val[11:0];
      REG_TURN_GAIN: cfg_shadow.turn_gain = val[11:0];
      REG_ARRIVE_RADIUS: cfg_shadow.arrive_radius = val[15:0];
      default: ;
    endcase
  endtask

  // pipeline must be empty before the config changes
  task automatic drain();
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic send_pose(longint px, longint py, longint ph, bit idle_ok);
    cfg_we <= 1'b0;
    if (idle_ok) begin
      while ($urandom_range(99) < 20) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start <= 1'b1;
    in_pose_x <= px[23:0];
    in_pose_y <= py[23:0];
    in_pose_heading <= ph[15:0];
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_cmds.push_back(predict_drive(px, py, ph));
  endtask

  task automatic end_burst();
    start <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    drive_cmd_t e;
    if (rst_n && out_strobe) begin
      if (pending_cmds.size() == 0) begin
        $error("result with no item pending");
        fail_count++;
      end else begin
        e = pending_cmds.pop_front();
        if (out_left_power !== e.left) begin
          $error("left_power exp %0d got %0d", e.left, out_left_power);
          fail_count++;
        end
        if (out_right_power !== e.right) begin
          $error("right_power exp %0d got %0d", e.right, out_right_power);
          fail_count++;
        end
        if (out_arrived !== e.arrived) begin
          $error("arrived exp %0d got %0d", e.arrived, out_arrived);
          fail_count++;
        end
      end
    end
  end

  function automatic longint rnd_pos(bit near);
    if (near) return longint'($urandom_range(8000)) - 4000;
    return longint'(signed'(24'($urandom)));
  endfunction

  task automatic random_phase(int n, bit near);
    longint px, py, ph;
    for (int i = 0; i < n; i++) begin
      px = rnd_pos(near);
      py = rnd_pos(near);
      if ($urandom_range(9) == 0) begin
        px = cfg_shadow.target_x;
        py = cfg_shadow.target_y;
      end
      ph = longint'($urandom_range(46080)) - 23040;
      send_pose(px, py, ph, !(near && i < n / 3));
    end
    end_burst();
  endtask

  pose_row_t dir_rows[$];

  initial begin
    pose_row_t row;
    drive_cmd_t k;
    cfg_shadow = '{target_x: 0, target_y: 0, target_heading: 0, max_speed: 17920,
                   drive_mode: MODE_FWD, drive_gain: 563, turn_gain: 768,
                   arrive_radius: 192};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // reset config: at target -> arrived, known result
    dir_rows.push_back('{0, 0, 0, 1, 0, 0, 1});
    dir_rows.push_back('{100, -50, 23040, 1, 0, 0, 1});
    dir_rows.push_back('{8388607, 8388607, 23040, 0, 0, 0, 0});
    dir_rows.push_back('{-8388608, -8388608, -23040, 0, 0, 0, 0});
    dir_rows.push_back('{-8388608, 0, 0, 0, 0, 0, 0});
    dir_rows.push_back('{0, -8388608, 11520, 0, 0, 0, 0});
    dir_rows.push_back('{0, 8388607, -11520, 0, 0, 0, 0});
    dir_rows.push_back('{5000, 0, 0, 0, 0, 0, 0});
    dir_rows.push_back('{5000, 1, 0, 0, 0, 0, 0});
    dir_rows.push_back('{5000, -1, 0, 0, 0, 0, 0});
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      send_pose(row.px, row.py, row.ph, 1'b0);
      if (row.has_known) begin
        k = pending_cmds[$];
        if (k.arrived !== row.ka || k.left !== row.kl[16:0] || k.right !== row.kr[16:0]) begin
          $error("directed row %0d table/predictor disagree", i);
          fail_count++;
        end
      end
    end
    end_burst();
    // zero offset with zero radius, modes incl. spare, zero clamp
    for (int m = 0; m < 4; m++) begin
      drain();
      write_reg(REG_ARRIVE_RADIUS, 0);
      write_reg(REG_DRIVE_MODE, m);
      write_reg(REG_TARGET_HEADING, m == 2 ? -11520 : 11520);
      send_pose(0, 0, 0, 1'b0);
      send_pose(0, 0, 23040, 1'b0);
      send_pose(-3000, 700, -23040, 1'b0);
      end_burst();
    end
    drain();
    write_reg(REG_MAX_SPEED, 0);
    send_pose(4000, 4000, 100, 1'b0);
    end_burst();
    drain();
    write_reg(REG_MAX_SPEED, 25600);
    write_reg(REG_DRIVE_GAIN, 4095);
    write_reg(REG_TURN_GAIN, 4095);
    send_pose(-8388608, 8388607, 23040, 1'b0);
    end_burst();

    // random phases over a spread of settings
    for (int p = 0; p < 13; p++) begin
      drain();
      write_reg(REG_TARGET_X, p == 0 ? 8388607 : p == 1 ? -8388608 : rnd_pos($urandom_range(1)));
      write_reg(REG_TARGET_Y, p == 0 ? -8388608 : p == 1 ? 8388607 : rnd_pos($urandom_range(1)));
      write_reg(REG_TARGET_HEADING, p == 0 ? 11520 : p == 1 ? -11520 :
                longint'($urandom_range(23040)) - 11520);
      write_reg(REG_MAX_SPEED, p == 2 ? 0 : p == 3 ? 25600 : $urandom_range(25600));
      write_reg(REG_DRIVE_MODE, p % 4);
      write_reg(REG_DRIVE_GAIN, p == 4 ? 0 : p == 5 ? 4095 : $urandom_range(4095));
      write_reg(REG_TURN_GAIN, p == 4 ? 4095 : p == 5 ? 0 : $urandom_range(4095));
      write_reg(REG_ARRIVE_RADIUS, p == 6 ? 65535 : p == 7 ? 0 : $urandom_range(2000));
      random_phase(N_RANDOM / 13, p % 2);
    end
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end
endmodule
